// ----- src/baro_sensor_compensation_defines.svh -----
// Assertion macros used by the checker file.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define BSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bsc check failed");

// next-cycle implication
`define BSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bsc check failed");

`endif

// ----- src/bsc_pkg.sv -----
package bsc_pkg;

    // item field widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int TEMP_W  = 15;
    localparam int PRESS_W = 17;
    localparam int S_DATA_W = 2 * RAW_W;
    localparam int M_DATA_W = TEMP_W + PRESS_W;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SENS     = 3'd0,
        CFG_OFF      = 3'd1,
        CFG_TCS      = 3'd2,
        CFG_TCO      = 3'd3,
        CFG_TREF     = 3'd4,
        CFG_TEMPSENS = 3'd5
    } cfg_idx_t;

    // pipeline depth and handshake control
    localparam int PIPE_STAGES = 11;
    typedef struct packed {
        logic [PIPE_STAGES-1:0] load;
        logic                   last_valid;
    } pipe_ctl_t;

    // internal widths, sized from the worst case of every coefficient
    localparam int DT_W    = 25;
    localparam int DT2_W   = 2 * DT_W;
    localparam int PROD_W  = 42;
    localparam int SQ_W    = 48;
    localparam int Q_W     = 19;
    localparam int Q2_W    = 2 * Q_W;
    localparam int OFF_W   = 40;
    localparam int T2_W    = 17;
    localparam int LO_W    = 36;
    localparam int CORR_W  = 39;
    localparam int SPLIT_W = 20;
    localparam int PPLO_W  = RAW_W + SPLIT_W;
    localparam int PPHI_W  = RAW_W + 1 + OFF_W - SPLIT_W;
    localparam int FULL_W  = 64;
    localparam int QUO_W   = 44;
    localparam int P_W     = 29;

    // scaling shifts of the compensation formulas
    localparam int TREF_SHIFT = 8;
    localparam int T_SHIFT    = 23;
    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SHIFT = 8;
    localparam int OFF_BASE   = 16;
    localparam int SENS_BASE  = 15;
    localparam int T2_SHIFT   = 31;
    localparam int PROD_SHIFT = 21;
    localparam int P_SHIFT    = 15;

    // temperatures in hundredths, pressure in hundredths of mbar
    localparam int T_REF      = 2000;
    localparam int T_VLOW_OFS = 3500;
    localparam int T_LOW      = -4000;
    localparam int T_HIGH     = 8500;
    localparam int P_LOW      = 10000;
    localparam int P_HIGH     = 120000;

    localparam logic [RAW_W-1:0] RAW_ALL_ONES = '1;

endpackage

// ----- src/bsc_pipe_ctl.sv -----
module bsc_pipe_ctl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                out_ready,
    output logic                in_ready,
    output bsc_pkg::pipe_ctl_t  ctl
);
    import bsc_pkg::*;

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic [PIPE_STAGES-1:0] load;

    // a stage takes new data when it is empty or its content moves on
    always_comb begin
        load[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            load[k] = !vld_reg[k] || load[k+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (load[0]) begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (load[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready       = load[0];
    assign ctl.load       = load;
    assign ctl.last_valid = vld_reg[PIPE_STAGES-1];

endmodule

// ----- src/baro_sensor_compensation.sv -----
// Pipeline: 11 register stages, stage 0 to stage 10; an accepted item shows on
// m_tvalid, with its result, once it has moved through all of them.
// Throughput: one item per cycle while the output is not stalled; empty
// stages close up while the output is stalled.
// Reset (aresetn low at a clock edge) empties the pipeline and clears the six
// calibration registers to zero.
module baro_sensor_compensation (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bsc_pkg::S_DATA_W-1:0]    s_tdata,   // raw_pressure, raw_temperature
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsc_pkg::M_DATA_W-1:0]    m_tdata,   // temp_centi, press_centi
    output logic                            m_tuser,   // valid_res
    input  logic                            cfg_wr_en,
    input  logic [bsc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bsc_pkg::COEF_W-1:0]      cfg_wr_data
);
    import bsc_pkg::*;

    localparam logic [PROD_W-1:0] T_RND    = {{(PROD_W-T_SHIFT){1'b0}}, {T_SHIFT{1'b1}}};
    localparam logic [PROD_W-1:0] OFF_RND  = {{(PROD_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{1'b1}}};
    localparam logic [PROD_W-1:0] SENS_RND = {{(PROD_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{1'b1}}};
    localparam logic [FULL_W-1:0] PROD_RND =
        {{(FULL_W-PROD_SHIFT){1'b0}}, {PROD_SHIFT{1'b1}}};
    localparam logic [QUO_W-1:0]  P_RND    = {{(QUO_W-P_SHIFT){1'b0}}, {P_SHIFT{1'b1}}};

    pipe_ctl_t ctl;

    bsc_pipe_ctl u_pipe_ctl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .ctl       (ctl)
    );

    // calibration words
    logic [COEF_W-1:0] sens_coef_reg, off_coef_reg, tcs_coef_reg;
    logic [COEF_W-1:0] tco_coef_reg, tref_coef_reg, tempsens_coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_coef_reg     <= '0;
            off_coef_reg      <= '0;
            tcs_coef_reg      <= '0;
            tco_coef_reg      <= '0;
            tref_coef_reg     <= '0;
            tempsens_coef_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_SENS:     sens_coef_reg     <= cfg_wr_data;
                CFG_OFF:      off_coef_reg      <= cfg_wr_data;
                CFG_TCS:      tcs_coef_reg      <= cfg_wr_data;
                CFG_TCO:      tco_coef_reg      <= cfg_wr_data;
                CFG_TREF:     tref_coef_reg     <= cfg_wr_data;
                CFG_TEMPSENS: tempsens_coef_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ---- stage 0: dT and raw value check
    logic [RAW_W-1:0]       raw_p, raw_t;
    logic                   s0_bad_next;
    logic signed [DT_W-1:0] s0_dt_next;
    logic [RAW_W-1:0]       s0_d1_reg;
    logic                   s0_bad_reg;
    logic signed [DT_W-1:0] s0_dt_reg;

    always_comb begin
        raw_p       = s_tdata[RAW_W-1:0];
        raw_t       = s_tdata[S_DATA_W-1:RAW_W];
        s0_bad_next = (raw_p == '0) || (raw_p == RAW_ALL_ONES) ||
                      (raw_t == '0) || (raw_t == RAW_ALL_ONES);
        s0_dt_next  = $signed({1'b0, raw_t}) -
                      $signed({1'b0, tref_coef_reg, {TREF_SHIFT{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            s0_d1_reg  <= raw_p;
            s0_bad_reg <= s0_bad_next;
            s0_dt_reg  <= s0_dt_next;
        end
    end

    // ---- stage 1: dT products
    logic signed [PROD_W-1:0] s1_m6_next, s1_m4_next, s1_m3_next;
    logic signed [DT2_W-1:0]  s1_sq_full;
    logic signed [PROD_W-1:0] s1_m6_reg, s1_m4_reg, s1_m3_reg;
    logic [SQ_W-1:0]          s1_sq_reg;
    logic [RAW_W-1:0]         s1_d1_reg;
    logic                     s1_bad_reg;

    always_comb begin
        s1_m6_next = PROD_W'(s0_dt_reg) * PROD_W'($signed({1'b0, tempsens_coef_reg}));
        s1_m4_next = PROD_W'(s0_dt_reg) * PROD_W'($signed({1'b0, tco_coef_reg}));
        s1_m3_next = PROD_W'(s0_dt_reg) * PROD_W'($signed({1'b0, tcs_coef_reg}));
        s1_sq_full = DT2_W'(s0_dt_reg) * DT2_W'(s0_dt_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            s1_m6_reg  <= s1_m6_next;
            s1_m4_reg  <= s1_m4_next;
            s1_m3_reg  <= s1_m3_next;
            s1_sq_reg  <= s1_sq_full[SQ_W-1:0];
            s1_d1_reg  <= s0_d1_reg;
            s1_bad_reg <= s0_bad_reg;
        end
    end

    // ---- stage 2: TEMP, OFF, SENS, T2 (quotients truncate toward zero)
    logic signed [PROD_W-1:0] m6_adj, m4_adj, m3_adj, m6_quo;
    logic signed [Q_W-1:0]    s2_q_next, s2_t_next;
    logic signed [OFF_W-1:0]  s2_off_next, s2_sens_next;
    logic [T2_W-1:0]          s2_t2_next;
    logic signed [Q_W-1:0]    s2_q_reg, s2_t_reg;
    logic signed [OFF_W-1:0]  s2_off_reg, s2_sens_reg;
    logic [T2_W-1:0]          s2_t2_reg;
    logic [RAW_W-1:0]         s2_d1_reg;
    logic                     s2_bad_reg;

    always_comb begin
        m6_adj       = s1_m6_reg + (s1_m6_reg[PROD_W-1] ? T_RND : '0);
        m4_adj       = s1_m4_reg + (s1_m4_reg[PROD_W-1] ? OFF_RND : '0);
        m3_adj       = s1_m3_reg + (s1_m3_reg[PROD_W-1] ? SENS_RND : '0);
        m6_quo       = m6_adj >>> T_SHIFT;
        s2_q_next    = Q_W'(m6_quo);
        s2_t_next    = s2_q_next + Q_W'(T_REF);
        s2_off_next  = OFF_W'($signed({1'b0, off_coef_reg, {OFF_BASE{1'b0}}})) +
                       OFF_W'(m4_adj >>> OFF_SHIFT);
        s2_sens_next = OFF_W'($signed({1'b0, sens_coef_reg, {SENS_BASE{1'b0}}})) +
                       OFF_W'(m3_adj >>> SENS_SHIFT);
        s2_t2_next   = T2_W'(s1_sq_reg >> T2_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            s2_q_reg    <= s2_q_next;
            s2_t_reg    <= s2_t_next;
            s2_off_reg  <= s2_off_next;
            s2_sens_reg <= s2_sens_next;
            s2_t2_reg   <= s2_t2_next;
            s2_d1_reg   <= s1_d1_reg;
            s2_bad_reg  <= s1_bad_reg;
        end
    end

    // ---- stage 3: squares for the low temperature corrections
    // q is TEMP - 2000; vq is TEMP + 1500
    logic signed [Q_W-1:0]   vq;
    logic signed [Q2_W-1:0]  lo_full, vlo_full;
    logic [LO_W-1:0]         s3_lo_reg, s3_vlo_reg;
    logic                    s3_low_reg, s3_vlow_reg;
    logic signed [Q_W-1:0]   s3_t_reg;
    logic [T2_W-1:0]         s3_t2_reg;
    logic signed [OFF_W-1:0] s3_off_reg, s3_sens_reg;
    logic [RAW_W-1:0]        s3_d1_reg;
    logic                    s3_bad_reg;

    always_comb begin
        vq       = s2_q_reg + Q_W'(T_VLOW_OFS);
        lo_full  = Q2_W'(s2_q_reg) * Q2_W'(s2_q_reg);
        vlo_full = Q2_W'(vq) * Q2_W'(vq);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            s3_lo_reg   <= lo_full[LO_W-1:0];
            s3_vlo_reg  <= vlo_full[LO_W-1:0];
            s3_low_reg  <= s2_q_reg[Q_W-1];
            s3_vlow_reg <= vq[Q_W-1];
            s3_t_reg    <= s2_t_reg;
            s3_t2_reg   <= s2_t2_reg;
            s3_off_reg  <= s2_off_reg;
            s3_sens_reg <= s2_sens_reg;
            s3_d1_reg   <= s2_d1_reg;
            s3_bad_reg  <= s2_bad_reg;
        end
    end

    // ---- stage 4: OFF2, SENS2 and final temperature
    logic [CORR_W-1:0]       lo_w, vlo_w, lo5, vlo7, vlo11;
    logic [CORR_W-1:0]       s4_off2_next, s4_sens2_next;
    logic signed [Q_W-1:0]   s4_t_next;
    logic [CORR_W-1:0]       s4_off2_reg, s4_sens2_reg;
    logic                    s4_low_reg;
    logic signed [Q_W-1:0]   s4_t_reg;
    logic signed [OFF_W-1:0] s4_off_reg, s4_sens_reg;
    logic [RAW_W-1:0]        s4_d1_reg;
    logic                    s4_bad_reg;

    always_comb begin
        lo_w          = CORR_W'(s3_lo_reg);
        vlo_w         = CORR_W'(s3_vlo_reg);
        lo5           = (lo_w << 2) + lo_w;
        vlo7          = (vlo_w << 3) - vlo_w;
        vlo11         = (vlo_w << 3) + (vlo_w << 1) + vlo_w;
        s4_off2_next  = (lo5 >> 1) + (s3_vlow_reg ? vlo7 : '0);
        s4_sens2_next = (lo5 >> 2) + (s3_vlow_reg ? (vlo11 >> 1) : '0);
        s4_t_next     = s3_low_reg ? s3_t_reg - $signed(Q_W'(s3_t2_reg)) : s3_t_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[4]) begin
            s4_off2_reg  <= s4_off2_next;
            s4_sens2_reg <= s4_sens2_next;
            s4_low_reg   <= s3_low_reg;
            s4_t_reg     <= s4_t_next;
            s4_off_reg   <= s3_off_reg;
            s4_sens_reg  <= s3_sens_reg;
            s4_d1_reg    <= s3_d1_reg;
            s4_bad_reg   <= s3_bad_reg;
        end
    end

    // ---- stage 5: corrected OFF and SENS
    logic signed [OFF_W-1:0] s5_off_next, s5_sens_next;
    logic signed [OFF_W-1:0] s5_off_reg, s5_sens_reg;
    logic signed [Q_W-1:0]   s5_t_reg;
    logic [RAW_W-1:0]        s5_d1_reg;
    logic                    s5_bad_reg;

    always_comb begin
        s5_off_next  = s4_low_reg ? s4_off_reg - $signed(OFF_W'(s4_off2_reg)) : s4_off_reg;
        s5_sens_next = s4_low_reg ? s4_sens_reg - $signed(OFF_W'(s4_sens2_reg)) :
                                    s4_sens_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[5]) begin
            s5_off_reg  <= s5_off_next;
            s5_sens_reg <= s5_sens_next;
            s5_t_reg    <= s4_t_reg;
            s5_d1_reg   <= s4_d1_reg;
            s5_bad_reg  <= s4_bad_reg;
        end
    end

    // ---- stage 6: D1 * SENS as two partial products
    logic [PPLO_W-1:0]        s6_pplo_next;
    logic signed [PPHI_W-1:0] s6_pphi_next;
    logic [PPLO_W-1:0]        s6_pplo_reg;
    logic signed [PPHI_W-1:0] s6_pphi_reg;
    logic signed [OFF_W-1:0]  s6_off_reg;
    logic signed [Q_W-1:0]    s6_t_reg;
    logic                     s6_bad_reg;

    always_comb begin
        s6_pplo_next = PPLO_W'(s5_d1_reg) * PPLO_W'(s5_sens_reg[SPLIT_W-1:0]);
        s6_pphi_next = PPHI_W'($signed({1'b0, s5_d1_reg})) *
                       PPHI_W'($signed(s5_sens_reg[OFF_W-1:SPLIT_W]));
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[6]) begin
            s6_pplo_reg <= s6_pplo_next;
            s6_pphi_reg <= s6_pphi_next;
            s6_off_reg  <= s5_off_reg;
            s6_t_reg    <= s5_t_reg;
            s6_bad_reg  <= s5_bad_reg;
        end
    end

    // ---- stage 7: combine partial products
    logic signed [FULL_W-1:0] s7_prod_next;
    logic signed [FULL_W-1:0] s7_prod_reg;
    logic signed [OFF_W-1:0]  s7_off_reg;
    logic signed [Q_W-1:0]    s7_t_reg;
    logic                     s7_bad_reg;

    always_comb begin
        s7_prod_next = (FULL_W'(s6_pphi_reg) <<< SPLIT_W) +
                       FULL_W'($signed({1'b0, s6_pplo_reg}));
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[7]) begin
            s7_prod_reg <= s7_prod_next;
            s7_off_reg  <= s6_off_reg;
            s7_t_reg    <= s6_t_reg;
            s7_bad_reg  <= s6_bad_reg;
        end
    end

    // ---- stage 8: D1 * SENS / 2^21
    logic signed [FULL_W-1:0] prod_adj, prod_quo;
    logic signed [QUO_W-1:0]  s8_quo_reg;
    logic signed [OFF_W-1:0]  s8_off_reg;
    logic signed [Q_W-1:0]    s8_t_reg;
    logic                     s8_bad_reg;

    always_comb begin
        prod_adj = s7_prod_reg + (s7_prod_reg[FULL_W-1] ? PROD_RND : '0);
        prod_quo = prod_adj >>> PROD_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[8]) begin
            s8_quo_reg <= QUO_W'(prod_quo);
            s8_off_reg <= s7_off_reg;
            s8_t_reg   <= s7_t_reg;
            s8_bad_reg <= s7_bad_reg;
        end
    end

    // ---- stage 9: subtract OFF
    logic signed [QUO_W-1:0] s9_num_next;
    logic signed [QUO_W-1:0] s9_num_reg;
    logic signed [Q_W-1:0]   s9_t_reg;
    logic                    s9_bad_reg;

    always_comb begin
        s9_num_next = s8_quo_reg - QUO_W'(s8_off_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[9]) begin
            s9_num_reg <= s9_num_next;
            s9_t_reg   <= s8_t_reg;
            s9_bad_reg <= s8_bad_reg;
        end
    end

    // ---- stage 10: pressure, range check, output register
    logic signed [QUO_W-1:0] num_adj, num_quo;
    logic signed [P_W-1:0]   p_val;
    logic                    res_ok;
    logic [TEMP_W-1:0]       temp_reg;
    logic [PRESS_W-1:0]      press_reg;
    logic                    vres_reg;

    always_comb begin
        num_adj = s9_num_reg + (s9_num_reg[QUO_W-1] ? P_RND : '0);
        num_quo = num_adj >>> P_SHIFT;
        p_val   = P_W'(num_quo);
        res_ok  = !s9_bad_reg &&
                  (s9_t_reg >= Q_W'(T_LOW)) && (s9_t_reg <= Q_W'(T_HIGH)) &&
                  (p_val >= P_W'(P_LOW)) && (p_val <= P_W'(P_HIGH));
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[10]) begin
            temp_reg  <= res_ok ? s9_t_reg[TEMP_W-1:0] : '0;
            press_reg <= res_ok ? p_val[PRESS_W-1:0] : '0;
            vres_reg  <= res_ok;
        end
    end

    assign m_tvalid = ctl.last_valid;
    assign m_tdata  = {press_reg, temp_reg};
    assign m_tuser  = vres_reg;

endmodule

// ----- src/bsc_checker.sv -----
`include "baro_sensor_compensation_defines.svh"

module bsc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bsc_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);
    import bsc_pkg::*;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN  = TEMP_W'(T_LOW);
    localparam logic signed [TEMP_W-1:0] TEMP_MAX  = TEMP_W'(T_HIGH);
    localparam logic [PRESS_W-1:0]       PRESS_MIN = PRESS_W'(P_LOW);
    localparam logic [PRESS_W-1:0]       PRESS_MAX = PRESS_W'(P_HIGH);

    logic signed [TEMP_W-1:0] temp_out;
    logic [PRESS_W-1:0]       press_out;

    assign temp_out  = $signed(m_tdata[TEMP_W-1:0]);
    assign press_out = m_tdata[M_DATA_W-1:TEMP_W];

    // rejected items carry zero fields
    `BSC_ASSERT_IMP(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == '0)

    // accepted results sit inside the sensor range
    `BSC_ASSERT_IMP(a_valid_range, m_tvalid && m_tuser, (temp_out >= TEMP_MIN) && (temp_out <= TEMP_MAX) && (press_out >= PRESS_MIN) && (press_out <= PRESS_MAX))

    // a free output side never blocks the input side
    `BSC_ASSERT_IMP(a_ready_through, m_tready, s_tready)

    // a stalled item holds
    `BSC_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- verif/tb.sv -----
module tb;
    import bsc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = PIPE_STAGES + 4;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS  = 40;

    localparam logic [COEF_W-1:0] COEF_MAX = '1;
    // addresses past the last calibration register; writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE0 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE1 = 3'd7;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [PRESS_W-1:0]       press;
        logic                     in_range;
    } reading_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [COEF_W-1:0]     cfg_wr_data = '0;

    logic [COEF_W-1:0] coef [6] = '{default: '0};
    reading_t          expected_readings [$];
    int                n_sent     = 0;
    int                n_checked  = 0;
    int                errors     = 0;
    int                burst_left = 0;
    bit                no_gaps    = 1'b0;
    int                hold_seq   = 0;
    int                hold_seen  = 0;
    int                hold_left  = 0;
    int                seg_left   = 0;
    int                stall_pct  = 0;
    int                cycle_cnt  = 0;

    baro_sensor_compensation uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // raw_pressure, raw_temperature
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // temp_centi, press_centi
        .m_tuser     (m_tuser),     // valid_res
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic reading_t compensate(input logic [RAW_W-1:0] d1,
                                            input logic [RAW_W-1:0] d2);
        longint c1, c2, c3, c4, c5, c6;
        longint dt, t, off, sens, p, below, vbelow, t2, off2, sens2;
        reading_t r;
        r  = '0;
        c1 = coef[CFG_SENS];
        c2 = coef[CFG_OFF];
        c3 = coef[CFG_TCS];
        c4 = coef[CFG_TCO];
        c5 = coef[CFG_TREF];
        c6 = coef[CFG_TEMPSENS];
        if (d1 == '0 || d1 == RAW_ALL_ONES || d2 == '0 || d2 == RAW_ALL_ONES)
            return r;
        dt   = longint'(d2) - (c5 <<< TREF_SHIFT);
        t    = T_REF + dt * c6 / (64'sd1 <<< T_SHIFT);
        off  = (c2 <<< OFF_BASE) + dt * c4 / (64'sd1 <<< OFF_SHIFT);
        sens = (c1 <<< SENS_BASE) + dt * c3 / (64'sd1 <<< SENS_SHIFT);
        if (t < T_REF) begin
            // second order correction, extra term when very cold
            below = (t - T_REF) * (t - T_REF);
            t2    = dt * dt / (64'sd1 <<< T2_SHIFT);
            off2  = 5 * below / 2;
            sens2 = 5 * below / 4;
            if (t < T_REF - T_VLOW_OFS) begin
                vbelow = (t - (T_REF - T_VLOW_OFS)) * (t - (T_REF - T_VLOW_OFS));
                off2   = off2 + 7 * vbelow;
                sens2  = sens2 + 11 * vbelow / 2;
            end
            t    = t - t2;
            off  = off - off2;
            sens = sens - sens2;
        end
        p = (longint'(d1) * sens / (64'sd1 <<< PROD_SHIFT) - off) / (64'sd1 <<< P_SHIFT);
        if (t < T_LOW || t > T_HIGH || p < P_LOW || p > P_HIGH)
            return r;
        r.temp     = t[TEMP_W-1:0];
        r.press    = p[PRESS_W-1:0];
        r.in_range = 1'b1;
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (errors < MAX_PRINTS)
            $display("ERROR: %s", msg);
        errors++;
    endtask

    // predict on every accepted item, check every accepted result
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_readings.push_back(compensate(s_tdata[RAW_W-1:0],
                                                       s_tdata[S_DATA_W-1:RAW_W]));
            if (m_tvalid && m_tready) begin
                if (expected_readings.size() == 0) begin
                    report_error("result with no item pending");
                end else begin
                    want = expected_readings.pop_front();
                    if ($signed(m_tdata[TEMP_W-1:0]) !== want.temp)
                        report_error($sformatf("result %0d temp_centi: got %0d expected %0d",
                            n_checked, $signed(m_tdata[TEMP_W-1:0]), want.temp));
                    if (m_tdata[M_DATA_W-1:TEMP_W] !== want.press)
                        report_error($sformatf("result %0d press_centi: got %0d expected %0d",
                            n_checked, m_tdata[M_DATA_W-1:TEMP_W], want.press));
                    if (m_tuser !== want.in_range)
                        report_error($sformatf("result %0d valid_res: got %0b expected %0b",
                            n_checked, m_tuser, want.in_range));
                    n_checked <= n_checked + 1;
                end
            end
        end
    end

    // receiver: random stall segments, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left <= $urandom_range(20, 200);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct <= 0;
                    2:       stall_pct <= 25;
                    3:       stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end else begin
                seg_left <= seg_left - 1;
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("** baro_sensor_compensation: FAILED **");
        $finish;
    end

    task automatic send_item(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = (no_gaps || $urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {d2, d1};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic wait_idle(input int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (n_checked != n_sent);
        repeat (extra) @(posedge aclk);
    endtask

    // leaves cfg_wr_en high; the caller lowers it after its last write
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        if (idx <= CFG_TEMPSENS)
            coef[idx] = val;
    endtask

    task automatic load_coefs(input logic [COEF_W-1:0] sens, input logic [COEF_W-1:0] off,
                              input logic [COEF_W-1:0] tcs, input logic [COEF_W-1:0] tco,
                              input logic [COEF_W-1:0] tref, input logic [COEF_W-1:0] tsens);
        write_reg(CFG_SENS, sens);
        write_reg(CFG_OFF, off);
        write_reg(CFG_TCS, tcs);
        write_reg(CFG_TCO, tco);
        write_reg(CFG_TREF, tref);
        write_reg(CFG_TEMPSENS, tsens);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_typical_coefs();
        load_coefs(40127, 36924, 23317, 23282, 33464, 28312);
    endtask

    // mostly plausible conversion pairs around the current reference temperature
    task automatic pick_item(output logic [RAW_W-1:0] d1, output logic [RAW_W-1:0] d2);
        int unsigned sel;
        longint span, v;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            d1 = RAW_W'($urandom);
            d2 = RAW_W'($urandom);
        end else if (sel < 18) begin
            d1 = RAW_W'($urandom);
            d2 = RAW_W'($urandom);
            case (sel % 4)
                0: d1 = '0;
                1: d1 = RAW_ALL_ONES;
                2: d2 = '0;
                default: d2 = RAW_ALL_ONES;
            endcase
        end else begin
            if (coef[CFG_TEMPSENS] == '0)
                span = 2000000;
            else
                span = (64'sd8000 <<< T_SHIFT) / longint'(coef[CFG_TEMPSENS]);
            if (span > 4000000)
                span = 4000000;
            v = (longint'(coef[CFG_TREF]) <<< TREF_SHIFT)
                + longint'($urandom_range(0, 32'(2 * span))) - span;
            if (v < 1)
                v = 1;
            if (v > longint'(RAW_ALL_ONES) - 1)
                v = longint'(RAW_ALL_ONES) - 1;
            d2 = v[RAW_W-1:0];
            d1 = RAW_W'($urandom_range(1500000, 15000000));
        end
    endtask

    // calibration words still at reset: nothing can come out in range
    task automatic test_reset_state();
        send_item(9085466, 8569150);
        send_item(24'h000001, 24'hFFFFFE);
        send_item(24'hFFFFFE, 24'h000001);
        wait_idle(SETTLE);
    endtask

    task automatic test_directed_points();
        localparam logic [RAW_W-1:0] D2_REF = 24'd8566784;   // C5 * 256
        load_typical_coefs();
        send_item(9085466, 8569150);
        send_item('0, 8569150);
        send_item(RAW_ALL_ONES, 8569150);
        send_item(9085466, '0);
        send_item(9085466, RAW_ALL_ONES);
        send_item('0, '0);
        send_item(RAW_ALL_ONES, RAW_ALL_ONES);
        send_item(24'h000001, 8569150);         // pressure far too low
        send_item(24'hFFFFFE, 8569150);         // pressure far too high
        send_item(9085466, 24'h000001);
        send_item(9085466, 24'hFFFFFE);
        send_item(9085466, D2_REF);                 // exactly 20.00 C
        send_item(9085466, D2_REF - 24'd300);       // just below 20.00 C
        send_item(9085466, D2_REF - 24'd600000);    // cold, second order
        send_item(9085466, D2_REF - 24'd1200000);   // very cold, extra term
        send_item(9085466, D2_REF - 24'd1700000);
        send_item(9085466, D2_REF - 24'd1900000);   // below -40.00 C
        send_item(9085466, D2_REF + 24'd1600000);
        send_item(9085466, D2_REF + 24'd2000000);   // above 85.00 C
        send_item(3000000, D2_REF);
        send_item(6000000, D2_REF);
        send_item(14000000, D2_REF);
        wait_idle(SETTLE);
    endtask

    task automatic test_spare_index();
        write_reg(CFG_ADDR_SPARE0, COEF_MAX);
        write_reg(CFG_ADDR_SPARE1, COEF_MAX);
        cfg_wr_en <= 1'b0;
        send_item(9085466, 8569150);
        send_item(9085466, 8000000);
        wait_idle(SETTLE);
    endtask

    task automatic test_random_traffic();
        logic [RAW_W-1:0] d1, d2;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_typical_coefs();
                1: load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
                2: load_coefs('0, '0, '0, '0, '0, '0);
                3: load_coefs(COEF_MAX, '0, COEF_MAX, '0,
                              COEF_W'($urandom_range(20000, 45000)), COEF_MAX);
                7: load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                              COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
                default: load_coefs(COEF_W'($urandom_range(30000, 60000)),
                                    COEF_W'($urandom_range(30000, 60000)),
                                    COEF_W'($urandom_range(15000, 40000)),
                                    COEF_W'($urandom_range(15000, 40000)),
                                    COEF_W'($urandom_range(25000, 40000)),
                                    COEF_W'($urandom_range(20000, 35000)));
            endcase
            for (int n = 0; n < 48; n++) begin
                pick_item(d1, d2);
                send_item(d1, d2);
                if (n == 30 && ph % 2 == 1)
                    wait_idle(0);     // let the pipeline run dry mid-phase
            end
            wait_idle(SETTLE);
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        logic [RAW_W-1:0] d1, d2;
        load_typical_coefs();
        hold_seq <= hold_seq + 1;
        no_gaps = 1'b1;
        for (int n = 0; n < 40; n++) begin
            pick_item(d1, d2);
            send_item(d1, d2);
        end
        no_gaps = 1'b0;
        wait_idle(SETTLE);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_directed_points();
        test_spare_index();
        test_random_traffic();
        test_backpressure();
        wait_idle(2 * SETTLE);
        if (expected_readings.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_readings.size()));
        if (errors == 0)
            $display("** baro_sensor_compensation: PASSED **");
        else
            $display("** baro_sensor_compensation: FAILED **");
        $finish;
    end

endmodule
